// ----- rtl/shadowed_glcd_pixel_writer_defines.svh -----
// assertion macros used by the pixel writer back end
`ifndef SHADOWED_GLCD_PIXEL_WRITER_DEFINES_SVH
`define SHADOWED_GLCD_PIXEL_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define SGPW_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sgpw assertion failed");
// antecedent implies consequent in the same cycle
`define SGPW_ASSERT_IMP(name, pre, post) \
  `SGPW_ASSERT(name, (pre) |-> (post))
`else
`define SGPW_ASSERT(name, prop)
`define SGPW_ASSERT_IMP(name, pre, post)
`endif
`endif

// ----- rtl/sgpw_pkg.sv -----
// shared types and constants of the shadowed graphic lcd pixel writer
package sgpw_pkg;

  // request modes
  localparam logic [1:0] MODE_DOT   = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_MERGE = 2'd2;

  // bus write kinds
  localparam logic [1:0] KIND_COLUMN = 2'd0;
  localparam logic [1:0] KIND_PAGE   = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  // position cache value for an unknown position
  localparam logic [7:0] UNKNOWN_POS = 8'd255;
  // lowest pixel bit of a page byte
  localparam logic [7:0] DOT_BIT     = 8'h01;

  // stream widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USER_W = 2;

  // entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // one addressed data write waiting for the bus
  typedef struct packed {
    logic [7:0] chip;  // chip number, from 1
    logic [7:0] col;   // column within the chip
    logic [7:0] row;   // pixel row addressed
    logic [7:0] data;  // new display byte
  } wr_req_t;

  // queue status seen by the producer and consumer
  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

endpackage

// ----- rtl/sgpw_queue.sv -----
// short fifo of pending display writes between front and back
module sgpw_queue
  import sgpw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  wr_req_t     push_data_i,
  input  logic        pop_i,
  output wr_req_t     pop_data_o,
  output queue_stat_t stat_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  wr_req_t         entry_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign stat_o.valid = (cnt_q != '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.valid;
  assign pop_data_o   = entry_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/sgpw_front.sv -----
// request front end: range check, shadow read-modify-write, queue push
module sgpw_front
  import sgpw_pkg::*;
#(
  parameter int unsigned DISP_WIDTH   = 128,
  parameter int unsigned DISP_HEIGHT  = 64,
  parameter int unsigned CHIP_COLUMNS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  x_i,
  input  logic [7:0]  y_i,
  input  logic [7:0]  page_i,
  input  logic [7:0]  mask_i,
  input  logic [7:0]  data_i,
  input  logic        dot_color_i,
  output logic        push_o,
  output wr_req_t     push_data_o,
  input  queue_stat_t q_stat_i
);

  localparam int unsigned NumPages   = (DISP_HEIGHT + 7) / 8;
  localparam int unsigned ShadowSize = DISP_WIDTH * NumPages;
  localparam int unsigned AddrW      = $clog2(ShadowSize);
  localparam int unsigned MaxChip    = (DISP_WIDTH - 1) / CHIP_COLUMNS + 1;
  localparam int unsigned ChipW      = $clog2(MaxChip + 1);
  // x / CHIP_COLUMNS as a multiply by a rounded-up reciprocal, exact for 8-bit x
  localparam int unsigned RecipShift = 16;
  localparam int unsigned Recip      = ((1 << RecipShift) + CHIP_COLUMNS - 1) / CHIP_COLUMNS;
  localparam int unsigned ProdW      = RecipShift + 8;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_MODIFY = 3'b100
  } front_state_e;

  front_state_e    state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;

  logic [7:0]       shadow_mem [ShadowSize];
  logic [7:0]       rd_data_q;

  // request held through the modify state
  logic [1:0]       mode_q;
  logic [7:0]       x_q, row_q, mask_q, data_q, bit_q;
  logic             color_q;
  logic [AddrW-1:0] addr_q;
  logic [ChipW-1:0] quo_q;

  logic             accept, in_range;
  logic [4:0]       page_idx;
  logic [AddrW-1:0] rd_addr;
  logic [ProdW-1:0] quo_prod;
  logic [7:0]       col_base, old_byte, new_byte;
  logic             skip, commit, mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  // classify the incoming request
  always_comb begin
    in_range = 1'b0;
    if (x_i < 8'(DISP_WIDTH)) begin
      case (mode_i)
        MODE_DOT:   in_range = (y_i < 8'(DISP_HEIGHT));
        MODE_BYTE,
        MODE_MERGE: in_range = (page_i < 8'(NumPages));
        default:    in_range = 1'b0;
      endcase
    end
  end

  assign page_idx = (mode_i == MODE_DOT) ? y_i[7:3] : page_i[4:0];
  assign rd_addr  = AddrW'(page_idx) * AddrW'(DISP_WIDTH) + AddrW'(x_i);
  assign quo_prod = ProdW'(x_i) * ProdW'(Recip);

  // capture the request and its shadow address
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      x_q     <= x_i;
      row_q   <= (mode_i == MODE_DOT) ? y_i : {page_i[4:0], 3'b000};
      mask_q  <= mask_i;
      data_q  <= data_i;
      bit_q   <= DOT_BIT << y_i[2:0];
      color_q <= dot_color_i;
      addr_q  <= rd_addr;
      quo_q   <= quo_prod[RecipShift +: ChipW];
    end
  end

  // new byte from the shadow value
  assign old_byte = rd_data_q;
  always_comb begin
    case (mode_q)
      MODE_DOT:   new_byte = color_q ? (old_byte | bit_q) : (old_byte & ~bit_q);
      MODE_BYTE:  new_byte = data_q;
      MODE_MERGE: new_byte = (old_byte & ~mask_q) | (data_q & mask_q);
      default:    new_byte = old_byte;
    endcase
  end

  assign skip   = (state_q == ST_MODIFY) && (mode_q == MODE_MERGE) && (new_byte == old_byte);
  assign commit = (state_q == ST_MODIFY) && !skip && !q_stat_i.full;

  // column within the chip
  assign col_base = 8'(quo_q) * 8'(CHIP_COLUMNS);

  assign push_o           = commit;
  assign push_data_o.chip = 8'(quo_q) + 8'd1;
  assign push_data_o.col  = x_q - col_base;
  assign push_data_o.row  = row_q;
  assign push_data_o.data = new_byte;

  // shadow write port: clearing sweep or committed byte
  assign mem_we    = (state_q == ST_CLEAR) || commit;
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : addr_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? 8'h00 : new_byte;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      shadow_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_data_q <= shadow_mem[rd_addr];
    end
  end

  // control sequence
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AddrW'(ShadowSize - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_range) begin
          state_d = ST_MODIFY;
        end
      end
      ST_MODIFY: begin
        if (skip || commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

endmodule

// ----- rtl/sgpw_back.sv -----
// bus write back end: position cache and beat sequencing
`include "shadowed_glcd_pixel_writer_defines.svh"
module sgpw_back
  import sgpw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_stat_t q_stat_i,
  input  wr_req_t     q_data_i,
  output logic        pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [1:0]  m_kind_o,
  output logic [1:0]  m_chip_o,
  output logic [7:0]  m_value_o,
  output logic        m_last_o
);

  logic [7:0] col_cache_q, col_cache_d;
  logic [7:0] row_cache_q, row_cache_d;
  logic [7:0] last_chip_q, last_chip_d;

  wr_req_t    req_q;
  logic       pend_col_q, pend_col_d;
  logic       pend_pg_q, pend_pg_d;
  logic       pend_data_q, pend_data_d;

  logic       m_valid_q, m_valid_d;
  logic [1:0] m_kind_q;
  logic [7:0] m_value_q;
  logic [1:0] m_chip_q;
  logic       m_last_q;

  logic       busy, pop, load_beat;
  logic [7:0] cc_eff, rc_eff;
  logic       need_col, need_pg;

  assign busy      = pend_col_q || pend_pg_q || pend_data_q;
  assign pop       = q_stat_i.valid && !busy;
  assign pop_o     = pop;
  assign load_beat = busy && (!m_valid_q || m_ready_i);

  // cached position as seen by this chip
  assign cc_eff   = (last_chip_q != q_data_i.chip) ? UNKNOWN_POS : col_cache_q;
  assign rc_eff   = (last_chip_q != q_data_i.chip) ? UNKNOWN_POS : row_cache_q;
  assign need_col = (cc_eff != q_data_i.col);
  assign need_pg  = (rc_eff[7:3] != q_data_i.row[7:3]);

  // cache and pending beat update
  always_comb begin
    col_cache_d = col_cache_q;
    row_cache_d = row_cache_q;
    last_chip_d = last_chip_q;
    pend_col_d  = pend_col_q;
    pend_pg_d   = pend_pg_q;
    pend_data_d = pend_data_q;
    if (pop) begin
      col_cache_d = q_data_i.col + 8'd1;
      row_cache_d = need_pg ? q_data_i.row : rc_eff;
      last_chip_d = q_data_i.chip;
      pend_col_d  = need_col;
      pend_pg_d   = need_pg;
      pend_data_d = 1'b1;
    end else if (load_beat) begin
      if (pend_col_q) begin
        pend_col_d = 1'b0;
      end else if (pend_pg_q) begin
        pend_pg_d = 1'b0;
      end else begin
        pend_data_d = 1'b0;
      end
    end
  end

  // output register valid
  always_comb begin
    m_valid_d = m_valid_q;
    if (load_beat) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cache_q <= UNKNOWN_POS;
      row_cache_q <= UNKNOWN_POS;
      last_chip_q <= 8'd0;
      pend_col_q  <= 1'b0;
      pend_pg_q   <= 1'b0;
      pend_data_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      col_cache_q <= col_cache_d;
      row_cache_q <= row_cache_d;
      last_chip_q <= last_chip_d;
      pend_col_q  <= pend_col_d;
      pend_pg_q   <= pend_pg_d;
      pend_data_q <= pend_data_d;
      m_valid_q   <= m_valid_d;
    end
  end

  // request and beat payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      req_q <= q_data_i;
    end
    if (load_beat) begin
      m_chip_q <= req_q.chip[1:0];
      if (pend_col_q) begin
        m_kind_q  <= KIND_COLUMN;
        m_value_q <= req_q.col;
        m_last_q  <= 1'b0;
      end else if (pend_pg_q) begin
        m_kind_q  <= KIND_PAGE;
        m_value_q <= {3'b000, req_q.row[7:3]};
        m_last_q  <= 1'b0;
      end else begin
        m_kind_q  <= KIND_DATA;
        m_value_q <= req_q.data;
        m_last_q  <= 1'b1;
      end
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_kind_o  = m_kind_q;
  assign m_chip_o  = m_chip_q;
  assign m_value_o = m_value_q;
  assign m_last_o  = m_last_q;

  // the data beat, and only it, closes a request
  `SGPW_ASSERT_IMP(a_last_is_data, m_valid_q, m_last_q == (m_kind_q == KIND_DATA))
  // address commands are always followed by a data beat
  `SGPW_ASSERT_IMP(a_cmd_has_data, pend_col_q || pend_pg_q, pend_data_q)
  // with no chip addressed yet both positions are unknown
  `SGPW_ASSERT_IMP(a_no_chip_unknown, last_chip_q == 8'd0,
                   col_cache_q == UNKNOWN_POS && row_cache_q == UNKNOWN_POS)
  // a new request is only taken once the previous one has fully issued
  `SGPW_ASSERT_IMP(a_pop_when_idle, pop, !pend_data_q)

endmodule

// ----- rtl/shadowed_glcd_pixel_writer.sv -----
// Shadowed graphic lcd pixel writer, top level. After reset the shadow
// frame buffer is cleared one byte per cycle, DISP_WIDTH * ceil(DISP_HEIGHT / 8)
// bytes (1024 with the defaults), and the input is not ready during that sweep.
// Each request then goes through the front end as a shadow read, then modify
// and write back, and lands in a two-entry queue; the back end issues one to
// three bus writes per request at one beat per cycle while the output is
// ready, and takes the next request only once the last one has issued. The
// input takes a new request only after the front end has finished the last.
// Out-of-range requests, mode 3 and merges that leave the byte unchanged are
// taken and give no output.
module shadowed_glcd_pixel_writer
  import sgpw_pkg::*;
#(
  parameter int unsigned DISP_WIDTH   = 128,
  parameter int unsigned DISP_HEIGHT  = 64,
  parameter int unsigned CHIP_COLUMNS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // x[7:0], y[15:8], page[23:16], mask[31:24], data[39:32], dot_color[40], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // mode[1:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // chip[1:0], value[9:2], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // write_kind[1:0]
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  output logic                  m_axis_tlast_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i
);

  logic        push, pop;
  wr_req_t     push_data, pop_data;
  queue_stat_t q_stat;
  logic [1:0]  out_chip;
  logic [7:0]  out_value;

  // request front end with shadow memory
  sgpw_front #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT),
    .CHIP_COLUMNS(CHIP_COLUMNS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .mode_i      (s_axis_tuser_i[1:0]),
    .x_i         (s_axis_tdata_i[7:0]),
    .y_i         (s_axis_tdata_i[15:8]),
    .page_i      (s_axis_tdata_i[23:16]),
    .mask_i      (s_axis_tdata_i[31:24]),
    .data_i      (s_axis_tdata_i[39:32]),
    .dot_color_i (s_axis_tdata_i[40]),
    .push_o      (push),
    .push_data_o (push_data),
    .q_stat_i    (q_stat)
  );

  // pending writes
  sgpw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  // bus write sequencing
  sgpw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .q_data_i  (pop_data),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_kind_o  (m_axis_tuser_o),
    .m_chip_o  (out_chip),
    .m_value_o (out_value),
    .m_last_o  (m_axis_tlast_o)
  );

  // output beat packing
  assign m_axis_tdata_o = {6'b000000, out_value, out_chip};

endmodule

// ----- bench/shadowed_glcd_pixel_writer_tb.sv -----
// self-checking testbench of the shadowed graphic lcd pixel writer
module shadowed_glcd_pixel_writer_tb
  import sgpw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DISP_WIDTH   = 128;
  localparam int unsigned DISP_HEIGHT  = 64;
  localparam int unsigned CHIP_COLUMNS = 64;
  localparam int unsigned SHADOW_BYTES = DISP_WIDTH * ((DISP_HEIGHT + 7) / 8);

  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 380;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // one bus write as seen on the output stream
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] chip;
    logic [7:0] value;
    logic       last;
  } bus_write_t;

  // shadow frame buffer and position cache, plus the bus writes still owed
  class bus_write_tracker;
    logic [7:0]  shadow [SHADOW_BYTES];
    logic [7:0]  col_cache;
    logic [7:0]  row_cache;
    int unsigned cur_chip;
    bus_write_t  expected_writes [$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned writes_checked;

    function new();
      foreach (shadow[i]) shadow[i] = '0;
      col_cache      = UNKNOWN_POS;
      row_cache      = UNKNOWN_POS;
      cur_chip       = 0;
      mismatches     = 0;
      requests       = 0;
      writes_checked = 0;
    endfunction

    function void queue_write(logic [1:0] kind, int unsigned chip, int unsigned value,
                              logic last);
      bus_write_t w;
      w.kind  = kind;
      w.chip  = chip[1:0];
      w.value = value[7:0];
      w.last  = last;
      expected_writes.push_back(w);
    endfunction

    // position commands as the cache needs them, then the data write
    function void address_and_write(int unsigned x, int unsigned row, logic [7:0] byte_val);
      int unsigned chip;
      int unsigned addr;
      int unsigned pg;
      chip = x / CHIP_COLUMNS + 1;
      addr = x % CHIP_COLUMNS;
      pg   = row / 8;
      if (cur_chip != chip) begin
        col_cache = UNKNOWN_POS;
        row_cache = UNKNOWN_POS;
      end
      if (col_cache != addr) begin
        queue_write(KIND_COLUMN, chip, addr, 1'b0);
        col_cache = addr[7:0];
      end
      if (row_cache / 8 != pg) begin
        queue_write(KIND_PAGE, chip, pg, 1'b0);
        row_cache = row[7:0];
      end
      cur_chip = chip;
      queue_write(KIND_DATA, chip, 32'(byte_val), 1'b1);
      col_cache = col_cache + 8'd1;
    endfunction

    // accepted request: update the shadow and note the writes it causes
    function void note_request(logic [1:0] mode, int unsigned x, int unsigned y,
                               int unsigned pg, logic [7:0] mask, logic [7:0] data,
                               logic color);
      int unsigned idx;
      logic [7:0]  old_val;
      logic [7:0]  new_val;
      requests++;
      if (x >= DISP_WIDTH) return;
      if (mode == MODE_DOT) begin
        if (y >= DISP_HEIGHT) return;
        idx     = (y / 8) * DISP_WIDTH + x;
        new_val = shadow[idx];
        if (color) new_val = new_val | (DOT_BIT << y[2:0]);
        else new_val = new_val & ~(DOT_BIT << y[2:0]);
        shadow[idx] = new_val;
        address_and_write(x, y, new_val);
      end else if (mode == MODE_BYTE || mode == MODE_MERGE) begin
        // page overflow counts as out of range, no wrapping
        if (pg * 8 >= DISP_HEIGHT) return;
        idx     = pg * DISP_WIDTH + x;
        old_val = shadow[idx];
        if (mode == MODE_BYTE) begin
          new_val = data;
        end else begin
          new_val = (old_val & ~mask) | (data & mask);
          if (new_val == old_val) return;
        end
        shadow[idx] = new_val;
        address_and_write(x, pg * 8, new_val);
      end
    endfunction

    // accepted output beat against the oldest owed write
    function void check_beat(logic [1:0] kind, logic [1:0] chip, logic [7:0] value,
                             logic last);
      bus_write_t exp_w;
      writes_checked++;
      if (expected_writes.size() == 0) begin
        $error("unexpected bus write: write_kind %0d chip %0d value %0d last %0d",
               kind, chip, value, last);
        mismatches++;
        return;
      end
      exp_w = expected_writes.pop_front();
      if (exp_w.kind !== kind) begin
        $error("write_kind: expected %0d, actual %0d", exp_w.kind, kind);
        mismatches++;
      end
      if (exp_w.chip !== chip) begin
        $error("chip: expected %0d, actual %0d", exp_w.chip, chip);
        mismatches++;
      end
      if (exp_w.value !== value) begin
        $error("value: expected %0d, actual %0d", exp_w.value, value);
        mismatches++;
      end
      if (exp_w.last !== last) begin
        $error("last: expected %0d, actual %0d", exp_w.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;
  logic                  m_valid;
  logic                  m_ready = 1'b0;

  bus_write_tracker tracker;
  bit               idle_on = 1'b1;
  int unsigned      cycles = 0;
  logic [7:0]       prev_x = '0;
  logic [7:0]       prev_y = '0;
  logic [7:0]       prev_pg = '0;

  shadowed_glcd_pixel_writer #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT),
    .CHIP_COLUMNS(CHIP_COLUMNS)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready)
  );

  always #1 clk = ~clk;

  // run time limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // output beat monitor
  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) begin
      tracker.check_beat(m_tuser, m_tdata[1:0], m_tdata[9:2], m_tlast);
    end
  end

  // offer one request and wait until the block accepts it
  task automatic send_request(logic [1:0] mode, logic [7:0] x, logic [7:0] y,
                              logic [7:0] pg, logic [7:0] mask, logic [7:0] data,
                              logic color);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {7'd0, color, data, mask, pg, y, x};
    s_tuser <= mode;
    s_valid <= 1'b1;
    do @(posedge clk); while (!s_ready);
    tracker.note_request(mode, 32'(x), 32'(y), 32'(pg), mask, data, color);
  endtask

  // random request, mostly in range, often the next column of the same page
  task automatic send_random();
    logic [1:0]  mode;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  pg;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) mode = MODE_DOT;
    else if (r < 68) mode = MODE_BYTE;
    else if (r < 96) mode = MODE_MERGE;
    else mode = MODE_UNUSED;
    y  = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, DISP_HEIGHT - 1));
    pg = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    r = $urandom_range(0, 9);
    if (r == 0) begin
      x = 8'($urandom);
    end else if (r < 4) begin
      // sequential column keeps the position cache hitting
      x  = 8'((prev_x + 8'd1) % DISP_WIDTH);
      y  = prev_y;
      pg = prev_pg;
    end else begin
      x = 8'($urandom_range(0, DISP_WIDTH - 1));
    end
    prev_x  = x;
    prev_y  = y;
    prev_pg = pg;
    send_request(mode, x, y, pg, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // receiver: random stalls, with one long hold to back up the block
  initial begin
    int unsigned stall;
    bit          held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (!held && tracker.writes_checked >= 80) begin
        stall = LONG_HOLD;
        held  = 1'b1;
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (!m_valid);
    end
  end

  // reset, directed requests, random requests, drain
  initial begin
    tracker = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // dots at the corners, cache hit on the next column, clear a dot
    send_request(MODE_DOT, 8'd0, 8'd0, 8'd0, 8'h00, 8'h00, 1'b1);
    send_request(MODE_DOT, 8'd1, 8'd0, 8'hff, 8'hff, 8'hff, 1'b1);
    send_request(MODE_DOT, 8'd127, 8'd63, 8'd0, 8'h00, 8'h00, 1'b1);
    send_request(MODE_DOT, 8'd127, 8'd63, 8'd0, 8'h00, 8'h00, 1'b0);
    send_request(MODE_DOT, 8'd10, 8'd17, 8'hff, 8'hff, 8'hff, 1'b1);
    // out of range column and row
    send_request(MODE_DOT, 8'd128, 8'd5, 8'd0, 8'h00, 8'h00, 1'b1);
    send_request(MODE_DOT, 8'd255, 8'd5, 8'd0, 8'h00, 8'h00, 1'b1);
    send_request(MODE_DOT, 8'd5, 8'd64, 8'd0, 8'h00, 8'h00, 1'b1);
    send_request(MODE_DOT, 8'd5, 8'd255, 8'd0, 8'h00, 8'h00, 1'b1);
    // whole bytes, page overflow
    send_request(MODE_BYTE, 8'd0, 8'd0, 8'd0, 8'h00, 8'hff, 1'b0);
    send_request(MODE_BYTE, 8'd127, 8'd0, 8'd7, 8'h00, 8'h00, 1'b0);
    send_request(MODE_BYTE, 8'd3, 8'd0, 8'd8, 8'h00, 8'h12, 1'b0);
    send_request(MODE_BYTE, 8'd3, 8'd0, 8'd255, 8'h00, 8'h12, 1'b0);
    // chip boundary both ways
    send_request(MODE_BYTE, 8'd64, 8'd0, 8'd3, 8'h00, 8'haa, 1'b0);
    send_request(MODE_BYTE, 8'd63, 8'd0, 8'd3, 8'h00, 8'h55, 1'b0);
    // merges that leave the byte unchanged, one that changes it, then out of range merges
    send_request(MODE_MERGE, 8'd63, 8'd0, 8'd3, 8'h00, 8'hff, 1'b0);
    send_request(MODE_MERGE, 8'd63, 8'd0, 8'd3, 8'hff, 8'h55, 1'b0);
    send_request(MODE_MERGE, 8'd63, 8'd0, 8'd3, 8'h0f, 8'hff, 1'b0);
    send_request(MODE_MERGE, 8'd200, 8'd0, 8'd1, 8'hff, 8'h01, 1'b0);
    send_request(MODE_MERGE, 8'd20, 8'd0, 8'd9, 8'hff, 8'h01, 1'b0);
    // unused mode
    send_request(MODE_UNUSED, 8'd5, 8'd5, 8'd1, 8'hff, 8'hff, 1'b1);
    // column cache advance over consecutive bytes
    send_request(MODE_BYTE, 8'd62, 8'd0, 8'd2, 8'h00, 8'h80, 1'b0);
    send_request(MODE_BYTE, 8'd63, 8'd0, 8'd2, 8'h00, 8'h01, 1'b0);
    send_request(MODE_BYTE, 8'd64, 8'd0, 8'd2, 8'h00, 8'h7e, 1'b0);

    // random part, with stretches of no idling on either side
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = ((i / 50) % 4) != 3;
      send_random();
    end
    s_valid <= 1'b0;
    idle_on = 1'b1;

    while (tracker.expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: dots, bytes, merges, unused mode, out of range",
             tracker.requests);
    $display("checked %0d bus writes with cache hits, misses and chip changes",
             tracker.writes_checked);
    if (tracker.mismatches == 0 && tracker.expected_writes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
